// File: sv/ogrd_pkg.sv
// Shared types and constants for the occupancy grid ray marcher.
// No dependencies; used by the ray unit, the top level and the checker by scoped names.
`default_nettype none
package ogrd_pkg;

	localparam int POS_W  = 26;
	localparam int PROD_W = 38;
	localparam int DIST_W = 21;
	localparam int RNG_W  = 20;
	localparam int TIME_W = 32;
	localparam int DIR_BITS = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] OP_INTEGRATE = 2'd0;
	localparam logic [1:0] OP_QUERY     = 2'd1;
	localparam logic [1:0] OP_DECAY     = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_FREE    = 2'd1;
	localparam logic [1:0] ST_OCC     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAY_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd6;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [19:0]        range_value;
		logic               range_finite;
		logic [31:0]        time_now;
	} req_t;

	typedef struct packed {
		logic [19:0] distance;
		logic        has_return;
		logic        origin_outside;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  state;
		logic [31:0] stamp;
	} cell_t;

	typedef struct packed {
		logic               sel_y;
		logic [DIST_W-1:0]  ray_d;
	} ray_ctl_t;

endpackage
`default_nettype wire

// File: sv/ogrd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ogrd_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: sv/ogrd_ray_unit.sv
// Shared sample-point unit: origin + round(dir * d / 2^14), one axis per cycle.
// Depends on ogrd_pkg.
`default_nettype none
module ogrd_ray_unit (
	input  wire logic                               clk,
	input  wire ogrd_pkg::ray_ctl_t                 ctl,
	input  wire logic signed [23:0]                 start_x,
	input  wire logic signed [23:0]                 start_y,
	input  wire logic signed [15:0]                 dir_x,
	input  wire logic signed [15:0]                 dir_y,
	output logic signed [ogrd_pkg::POS_W-1:0]       pos_s2
);
	logic signed [ogrd_pkg::PROD_W-1:0] prod_s1;
	logic signed [23:0]                 org_s1;
	logic signed [15:0]                 dir_sel;
	logic signed [ogrd_pkg::PROD_W-1:0] rnd;
	logic signed [ogrd_pkg::PROD_W-1:0] shf;

	assign dir_sel = ctl.sel_y ? dir_y : dir_x;
	assign rnd = prod_s1 + ogrd_pkg::PROD_W'(1 << (ogrd_pkg::DIR_BITS - 1));
	assign shf = rnd >>> ogrd_pkg::DIR_BITS;

	always_ff @(posedge clk) begin
		prod_s1 <= ogrd_pkg::PROD_W'(dir_sel * $signed({1'b0, ctl.ray_d}));
		org_s1  <= ctl.sel_y ? start_y : start_x;
		pos_s2  <= ogrd_pkg::POS_W'(org_s1) + shf[ogrd_pkg::POS_W-1:0];
	end
endmodule
`default_nettype wire

// File: sv/occupancy_grid_raycast_decay_top.sv
// Occupancy grid ray marcher, one transaction at a time. Steps from accept to next accept:
// integrate visits the origin cell, each free step, then the hit cell or a last range check;
// query visits the origin, each sample, then a last range check; an origin outside the grid
// ends the transaction; decay goes straight to the result, or sweeps every cell first.
// Result valid rises in the same cycle that req_stall drops; a stalled result holds the block.
// After reset the cell memory is cleared to unknown with req_stall high.
`default_nettype none
module occupancy_grid_raycast_decay_top #(
	parameter int GRID_WIDTH  = 256,
	parameter int GRID_HEIGHT = 256,
	parameter int FRAC_BITS   = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire ogrd_pkg::req_t                       req,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output ogrd_pkg::rsp_t                            rsp,
	input  wire logic                                 cfg_we,
	input  wire logic [ogrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ogrd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int MW    = ogrd_pkg::POS_W - 1 - FRAC_BITS;
	localparam int DW    = ogrd_pkg::DIST_W;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_CHECK = 10'b00_0000_0100,
		S_MX    = 10'b00_0000_1000,
		S_MY    = 10'b00_0001_0000,
		S_PX    = 10'b00_0010_0000,
		S_CELL  = 10'b00_0100_0000,
		S_QCHK  = 10'b00_1000_0000,
		S_SWEEP = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		PH_ORIGIN = 4'b0001,
		PH_FREE   = 4'b0010,
		PH_HIT    = 4'b0100,
		PH_QUERY  = 4'b1000
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	ogrd_pkg::req_t item_q;
	ogrd_pkg::rsp_t res_q;
	logic [19:0] scan_min_q, scan_max_q, qmin_q, qmax_q;
	logic [15:0] step_cfg_q, step_q;
	logic [31:0] timeout_q, period_q, last_q;
	logic [DW-1:0] d_q;
	logic [19:0] limit_q;
	logic hit_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [ogrd_pkg::POS_W-1:0] px_q, pos_s2;
	logic rsp_valid_q;

	ogrd_pkg::ray_ctl_t ray_ctl;
	ogrd_pkg::cell_t wcell, rcell;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [MW-1:0] mx, my;
	logic in_grid;
	logic [AW-1:0] idx;
	logic [DW-1:0] d_next;
	logic req_hit;
	logic [19:0] req_limit;
	logic signed [33:0] elapsed, age;
	logic expire;

	assign mx = px_q[ogrd_pkg::POS_W-2:FRAC_BITS];
	assign my = pos_s2[ogrd_pkg::POS_W-2:FRAC_BITS];
	assign in_grid = !px_q[ogrd_pkg::POS_W-1] && !pos_s2[ogrd_pkg::POS_W-1]
		&& (mx < MW'(GRID_WIDTH)) && (my < MW'(GRID_HEIGHT));
	assign idx = AW'(AW'(my) * AW'(GRID_WIDTH)) + AW'(mx);
	assign d_next = d_q + DW'(step_q);

	assign req_hit = req.range_finite && (req.range_value >= scan_min_q)
		&& (req.range_value < scan_max_q);
	always_comb begin
		if (req_hit) begin
			req_limit = (req.range_value != 20'd0) ? req.range_value - 20'd1 : 20'd0;
		end else if (req.range_finite) begin
			req_limit = (req.range_value < scan_max_q) ? req.range_value : scan_max_q;
		end else begin
			req_limit = scan_max_q;
		end
	end

	assign elapsed = $signed({2'b00, req.time_now}) - $signed({2'b00, last_q});
	assign age = $signed({2'b00, item_q.time_now}) - $signed({2'b00, rcell.stamp});
	assign expire = (rcell.state == ogrd_pkg::ST_OCC) && (rcell.stamp != 32'd0)
		&& (age > $signed({2'b00, timeout_q}));

	assign ray_ctl.sel_y = (state_q == S_MY);
	assign ray_ctl.ray_d = d_q;

	ogrd_ray_unit u_ray (
		.clk      (clk),
		.ctl      (ray_ctl),
		.start_x  (item_q.start_x),
		.start_y  (item_q.start_y),
		.dir_x    (item_q.dir_x),
		.dir_y    (item_q.dir_y),
		.pos_s2   (pos_s2)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx;
		ram_raddr = idx;
		wcell.state = ogrd_pkg::ST_FREE;
		wcell.stamp = item_q.time_now;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				wcell.state = ogrd_pkg::ST_UNKNOWN;
				wcell.stamp = 32'd0;
			end
			S_CELL: begin
				if (in_grid && (phase_q != PH_QUERY)) begin
					ram_we = !(phase_q == PH_ORIGIN && item_q.operation == ogrd_pkg::OP_QUERY);
					if (phase_q == PH_HIT) begin
						wcell.state = ogrd_pkg::ST_OCC;
					end
				end
			end
			S_SWEEP: begin
				ram_raddr = cnt_q[AW-1:0];
				ram_waddr = AW'(cnt_q - CNT_W'(1));
				ram_we = (cnt_q != '0) && expire;
				wcell.state = ogrd_pkg::ST_UNKNOWN;
				wcell.stamp = 32'd0;
			end
			default: begin
			end
		endcase
	end

	ogrd_ram #(
		.WIDTH ($bits(ogrd_pkg::cell_t)),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wcell),
		.raddr (ram_raddr),
		.rdata (rcell)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_min_q <= 20'd0;
			scan_max_q <= 20'd1048575;
			qmin_q <= 20'd256;
			qmax_q <= 20'd153600;
			step_cfg_q <= 16'd128;
			timeout_q <= 32'd6000;
			period_q <= 32'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogrd_pkg::CFG_SCAN_MIN:  scan_min_q <= cfg_data[19:0];
				ogrd_pkg::CFG_SCAN_MAX:  scan_max_q <= cfg_data[19:0];
				ogrd_pkg::CFG_QUERY_MIN: qmin_q <= cfg_data[19:0];
				ogrd_pkg::CFG_QUERY_MAX: qmax_q <= cfg_data[19:0];
				ogrd_pkg::CFG_RAY_STEP:  step_cfg_q <= cfg_data[15:0];
				ogrd_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data;
				ogrd_pkg::CFG_PERIOD:    period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PX) begin
			px_q <= pos_s2;
		end
		if (state_q == S_IDLE && req_valid) begin
			item_q <= req;
			hit_q <= req_hit;
			limit_q <= req_limit;
			step_q <= (step_cfg_q != 16'd0) ? step_cfg_q : 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= PH_ORIGIN;
			cnt_q <= '0;
			d_q <= '0;
			last_q <= 32'd0;
			res_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						res_q <= '0;
						d_q <= '0;
						cnt_q <= '0;
						phase_q <= PH_ORIGIN;
						case (req.operation) inside
							ogrd_pkg::OP_INTEGRATE, ogrd_pkg::OP_QUERY: begin
								state_q <= S_MX;
							end
							ogrd_pkg::OP_DECAY: begin
								if (timeout_q != 32'd0 && last_q != 32'd0
										&& elapsed >= $signed({2'b00, period_q})) begin
									last_q <= req.time_now;
									state_q <= S_SWEEP;
								end else begin
									if (timeout_q != 32'd0 && last_q == 32'd0) begin
										last_q <= req.time_now;
									end
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CHECK: begin
					if (phase_q == PH_QUERY) begin
						state_q <= (d_q <= DW'(qmax_q)) ? S_MX : S_DONE;
					end else if (d_q <= DW'(limit_q)) begin
						state_q <= S_MX;
					end else if (hit_q) begin
						d_q <= DW'(item_q.range_value);
						phase_q <= PH_HIT;
						state_q <= S_MX;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_PX;
				S_PX: state_q <= S_CELL;
				S_CELL: begin
					unique case (phase_q)
						PH_ORIGIN: begin
							if (!in_grid) begin
								res_q.origin_outside <= 1'b1;
								state_q <= S_DONE;
							end else if (item_q.operation == ogrd_pkg::OP_INTEGRATE) begin
								d_q <= DW'(step_q);
								phase_q <= PH_FREE;
								state_q <= S_CHECK;
							end else begin
								d_q <= DW'(qmin_q);
								phase_q <= PH_QUERY;
								state_q <= S_CHECK;
							end
						end
						PH_FREE: begin
							d_q <= d_next;
							state_q <= S_CHECK;
						end
						PH_HIT: state_q <= S_DONE;
						PH_QUERY: state_q <= in_grid ? S_QCHK : S_DONE;
						default: state_q <= S_DONE;
					endcase
				end
				S_QCHK: begin
					if (rcell.state == ogrd_pkg::ST_UNKNOWN) begin
						state_q <= S_DONE;
					end else if (rcell.state == ogrd_pkg::ST_OCC) begin
						res_q.distance <= d_q[19:0];
						res_q.has_return <= 1'b1;
						state_q <= S_DONE;
					end else begin
						d_q <= d_next;
						state_q <= S_CHECK;
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CELLS)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp <= res_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
endmodule
`default_nettype wire

// File: sv/ogrd_checker.sv
// Port-level checks for the occupancy grid ray marcher, bound to the top level.
// Depends on ogrd_pkg and occupancy_grid_raycast_decay_top.
`default_nettype none
module ogrd_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire ogrd_pkg::rsp_t rsp
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("accepted transaction did not make the block busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a transaction in progress");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> req_stall && !rsp_valid)
		else $error("block not quiet in reset");
endmodule

bind occupancy_grid_raycast_decay_top ogrd_checker u_ogrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
